// ===== rtl/rtc_pkg.sv =====
`timescale 1ns / 1ps
package rtc_pkg;

  localparam int CW = 11;            // index and count width
  localparam int VW = 16;            // element value width
  localparam int SW = 26;            // range sum width
  localparam int TW = 16;            // totient table address width
  localparam int LW = 8;             // least prime factor width
  localparam int MAX_VALUE = 65535;
  localparam int ELEMENTS_DEF = 1024;
  localparam int NPR = 54;           // primes below 256

  localparam logic [1:0] CMD_PHI = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_SUM = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [LW-1:0] PRIMES [NPR] = '{
    8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29,
    8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71,
    8'd73, 8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
    8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167,
    8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211, 8'd223,
    8'd227, 8'd229, 8'd233, 8'd239, 8'd241, 8'd251
  };

  typedef enum logic [2:0] {
    T_CLR, T_RD, T_GET, T_MUL, T_WR, T_DONE
  } sieve_state_t;

  typedef enum logic [2:0] {
    R_CLR, R_IDLE, R_RD, R_GET, R_PHI, R_DONE
  } range_state_t;

endpackage

// ===== rtl/rtc_ram.sv =====
`timescale 1ns / 1ps
module rtc_ram #(
  parameter int W = 16,
  parameter int D = 1024,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rtc_sieve.sv =====
`timescale 1ns / 1ps
module rtc_sieve (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [rtc_pkg::TW-1:0] lut_addr,
  output logic [rtc_pkg::VW-1:0] lut_data,
  output logic                  tbl_done
);
  import rtc_pkg::*;

  sieve_state_t state, state_next;

  logic [TW-1:0]   i;
  logic [TW-1:0]   ctr;
  logic [5:0]      j;
  logic [TW-1:0]   bound;
  logic [VW-1:0]   phi_i;
  logic [TW+LW-1:0] m;
  logic [VW+LW-1:0] prod;

  logic [LW-1:0] pj;
  logic          last_i;
  logic          no_lpf;

  logic          phi_we, lpf_we;
  logic [TW-1:0] phi_waddr, lpf_waddr, phi_raddr;
  logic [VW-1:0] phi_wdata, phi_rdata;
  logic [LW-1:0] lpf_wdata, lpf_rdata;

  rtc_ram #(.W(VW), .D(MAX_VALUE + 1), .AW(TW)) u_phi (
    .clk(clk), .we(phi_we), .waddr(phi_waddr), .wdata(phi_wdata),
    .raddr(phi_raddr), .rdata(phi_rdata)
  );

  rtc_ram #(.W(LW), .D(MAX_VALUE + 1), .AW(TW)) u_lpf (
    .clk(clk), .we(lpf_we), .waddr(lpf_waddr), .wdata(lpf_wdata),
    .raddr(i), .rdata(lpf_rdata)
  );

  assign pj       = (j < 6'(NPR)) ? PRIMES[j] : '0;
  assign last_i   = (i == TW'(MAX_VALUE));
  assign no_lpf   = (lpf_rdata == '0);
  assign lut_data = phi_rdata;
  assign tbl_done = (state == T_DONE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_CLR: if (ctr == TW'(MAX_VALUE)) state_next = T_RD;
      T_RD:  state_next = T_GET;
      T_GET: state_next = T_MUL;
      T_MUL: begin
        if (j == 6'(NPR) || TW'(pj) > bound) begin
          state_next = last_i ? T_DONE : T_RD;
        end else begin
          state_next = T_WR;
        end
      end
      T_WR: begin
        if (m > (TW+LW)'(MAX_VALUE) || TW'(pj) == bound) begin
          state_next = last_i ? T_DONE : T_RD;
        end else begin
          state_next = T_MUL;
        end
      end
      T_DONE: state_next = T_DONE;
      default: state_next = T_CLR;
    endcase
  end

  // table write and read controls
  always_comb begin
    phi_we    = 1'b0;
    phi_waddr = ctr;
    phi_wdata = '0;
    lpf_we    = 1'b0;
    lpf_waddr = ctr;
    lpf_wdata = '0;
    phi_raddr = (state == T_DONE) ? lut_addr : i;
    unique case (state)
      T_CLR: begin
        phi_we    = 1'b1;
        lpf_we    = 1'b1;
        phi_wdata = (ctr == TW'(1)) ? VW'(1) : '0;
      end
      T_GET: begin
        phi_we    = no_lpf;
        phi_waddr = i;
        phi_wdata = i - TW'(1);
      end
      T_WR: begin
        if (m <= (TW+LW)'(MAX_VALUE)) begin
          phi_we    = 1'b1;
          lpf_we    = 1'b1;
          phi_waddr = m[TW-1:0];
          lpf_waddr = m[TW-1:0];
          phi_wdata = prod[VW-1:0];
          lpf_wdata = pj;
        end
      end
      default: ;
    endcase
  end

  // sieve registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLR;
      ctr   <= '0;
      i     <= TW'(2);
      j     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        T_CLR: ctr <= ctr + TW'(1);
        T_GET: begin
          phi_i <= no_lpf ? i - TW'(1) : phi_rdata;
          bound <= no_lpf ? i : TW'(lpf_rdata);
          j     <= '0;
        end
        T_MUL: begin
          m    <= pj * i;
          prod <= phi_i * ((TW'(pj) == bound) ? pj : pj - LW'(1));
          if (state_next != T_WR && !last_i) i <= i + TW'(1);
        end
        T_WR: begin
          j <= j + 6'd1;
          if (state_next == T_RD) i <= i + TW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rtc_range.sv =====
`timescale 1ns / 1ps
module rtc_range #(
  parameter int ELEMENTS = rtc_pkg::ELEMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [rtc_pkg::CW-1:0] cnt,
  input  logic                   tbl_done,
  output logic [rtc_pkg::TW-1:0] lut_addr,
  input  logic [rtc_pkg::VW-1:0] lut_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [rtc_pkg::CW-1:0] range_low,
  input  logic [rtc_pkg::CW-1:0] range_high,
  input  logic [rtc_pkg::VW-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [rtc_pkg::SW-1:0] range_sum
);
  import rtc_pkg::*;

  localparam int EAW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  range_state_t state, state_next;

  logic           clr_pend;
  logic [EAW-1:0] ctr;
  logic [1:0]     cmd;
  logic [CW-1:0]  idx, hi_eff;
  logic [VW-1:0]  val;
  logic [SW-1:0]  acc;

  logic [CW-1:0]  lo_in, hi_in;
  logic           empty_in, accept, last_idx, load_out;
  logic [SW:0]    acc_sum;

  logic           e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [VW-1:0]  e_wdata, e_rdata;

  rtc_ram #(.W(VW), .D(ELEMENTS), .AW(EAW)) u_elem (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  // clip the range to the elements in use
  assign lo_in    = (range_low == '0) ? CW'(1) : range_low;
  assign hi_in    = (range_high > cnt) ? cnt : range_high;
  assign empty_in = (lo_in > hi_in);
  assign accept   = in_valid && in_ready;
  assign last_idx = (idx == hi_eff);
  assign acc_sum  = {1'b0, acc} + (SW+1)'(e_rdata);
  assign load_out = (state == R_DONE) && (!out_valid || out_ready);
  assign lut_addr = e_rdata;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      R_CLR: if (ctr == EAW'(ELEMENTS - 1) && !cfg_we) state_next = R_IDLE;
      R_IDLE: begin
        if (clr_pend) begin
          state_next = R_CLR;
        end else if (accept) begin
          if (command == CMD_PHI || command == CMD_SET || command == CMD_SUM) begin
            if (!empty_in) state_next = R_RD;
            else if (command == CMD_SUM) state_next = R_DONE;
          end
        end
      end
      R_RD: state_next = R_GET;
      R_GET: begin
        if (cmd == CMD_PHI && e_rdata > VW'(1)) state_next = R_PHI;
        else if (last_idx) state_next = (cmd == CMD_SUM) ? R_DONE : R_IDLE;
        else state_next = R_RD;
      end
      R_PHI: state_next = last_idx ? R_IDLE : R_RD;
      R_DONE: if (load_out) state_next = R_IDLE;
      default: state_next = R_CLR;
    endcase
  end

  // element store controls and input handshake
  always_comb begin
    in_ready = (state == R_IDLE) && !clr_pend && tbl_done;
    e_raddr  = EAW'(idx - CW'(1));
    e_waddr  = e_raddr;
    e_we     = 1'b0;
    e_wdata  = '0;
    unique case (state)
      R_CLR: begin
        e_we    = 1'b1;
        e_waddr = ctr;
      end
      R_GET: begin
        e_we    = (cmd == CMD_SET);
        e_wdata = val;
      end
      R_PHI: begin
        e_we    = 1'b1;
        e_wdata = lut_data;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= R_CLR;
      ctr       <= '0;
      clr_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) clr_pend <= 1'b1;
      else if (state == R_IDLE) clr_pend <= 1'b0;
      if (state == R_CLR) ctr <= (cfg_we || state_next != R_CLR) ? '0 : ctr + EAW'(1);
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // hold the item, step the index and accumulate the sum
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= command;
      idx    <= lo_in;
      hi_eff <= hi_in;
      val    <= value;
      acc    <= '0;
    end else begin
      if (state == R_GET && cmd == CMD_SUM) begin
        acc <= acc_sum[SW] ? '1 : acc_sum[SW-1:0];
      end
      if ((state == R_GET && state_next == R_RD) || (state == R_PHI && !last_idx)) begin
        idx <= idx + CW'(1);
      end
    end
    if (load_out) range_sum <= acc;
  end

endmodule

// ===== rtl/range_totient_assign_sum_tree.sv =====
`timescale 1ns / 1ps
// Channel   Handshake              Word
// in        in_valid / in_ready    command, range_low, range_high, value
// out       out_valid / out_ready  range_sum (sum queries only)
// cfg       cfg_we                 cfg_wdata (element count)
//
// An item reads and then handles each element of the clipped range in turn
// (with a totient write for a value above 1); one element store port sets the
// pace. After reset the table is cleared and sieved; the element store is
// cleared after reset and after every count write. A waiting result stalls the
// next sum query and every item behind it.
module range_totient_assign_sum_tree #(
  parameter int ELEMENTS = rtc_pkg::ELEMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [rtc_pkg::CW-1:0] cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [rtc_pkg::CW-1:0] range_low,
  input  logic [rtc_pkg::CW-1:0] range_high,
  input  logic [rtc_pkg::VW-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [rtc_pkg::SW-1:0] range_sum
);
  import rtc_pkg::*;

  localparam int CNT_RST = (ELEMENTS < 1024) ? ELEMENTS : 1024;

  logic [CW-1:0] cnt;
  logic [TW-1:0] lut_addr;
  logic [VW-1:0] lut_data;
  logic          tbl_done;

  // clamp the element count into 1..ELEMENTS
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CW'(CNT_RST);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) cnt <= CW'(1);
      else if (cfg_wdata > CW'(ELEMENTS)) cnt <= CW'(ELEMENTS);
      else cnt <= cfg_wdata;
    end
  end

  rtc_sieve u_sieve (
    .clk(clk), .rst(rst), .lut_addr(lut_addr), .lut_data(lut_data),
    .tbl_done(tbl_done)
  );

  rtc_range #(.ELEMENTS(ELEMENTS)) u_range (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cnt(cnt), .tbl_done(tbl_done),
    .lut_addr(lut_addr), .lut_data(lut_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .range_low(range_low), .range_high(range_high), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum)
  );

`ifndef SYNTHESIS
  a_ready_after_table: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> tbl_done) else $error("word taken before table built");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready) else $error("input open during element clear");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised right after accept");
`endif

endmodule

// ===== bench/tb_checker.sv =====
`timescale 1ns / 1ps
module tb_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [rtc_pkg::CW-1:0] cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             command,
  input  logic [rtc_pkg::CW-1:0] range_low,
  input  logic [rtc_pkg::CW-1:0] range_high,
  input  logic [rtc_pkg::VW-1:0] value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [rtc_pkg::SW-1:0] range_sum,
  output int                     fail_count,
  output int                     open_sums,
  output int                     sums_checked
);
  import rtc_pkg::*;

  localparam longint SUM_CAP = (64'd1 << SW) - 1;

  logic [VW-1:0] elem_val [1:ELEMENTS_DEF];
  logic [VW-1:0] phi_of [0:MAX_VALUE];
  logic [SW-1:0] sum_due [$];
  int            live_count;

  // Build the totient table by sieving each prime over its multiples
  initial begin
    int t [0:MAX_VALUE];
    for (int i = 0; i <= MAX_VALUE; i++) t[i] = i;
    for (int p = 2; p <= MAX_VALUE; p++) begin
      if (t[p] == p) begin
        for (int m = p; m <= MAX_VALUE; m += p) t[m] -= t[m] / p;
      end
    end
    for (int i = 0; i <= MAX_VALUE; i++) phi_of[i] = t[i][VW-1:0];
  end

  task automatic clear_elems();
    for (int i = 1; i <= ELEMENTS_DEF; i++) elem_val[i] = '0;
  endtask

  // Apply one accepted word to the element model
  task automatic apply_word(logic [1:0] cmd, int lo, int hi, logic [VW-1:0] v);
    int     first;
    int     last;
    longint acc;
    first = (lo < 1) ? 1 : lo;
    last = (hi > live_count) ? live_count : hi;
    acc = 0;
    for (int i = first; i <= last; i++) begin
      case (cmd)
        CMD_PHI: if (elem_val[i] > 1) elem_val[i] = phi_of[elem_val[i]];
        CMD_SET: elem_val[i] = v;
        CMD_SUM: acc += elem_val[i];
        default: ;
      endcase
    end
    if (cmd == CMD_SUM) begin
      if (acc > SUM_CAP) acc = SUM_CAP;
      sum_due.push_back(acc[SW-1:0]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_elems();
      live_count = ELEMENTS_DEF;
      sum_due.delete();
      fail_count = 0;
      sums_checked = 0;
    end else begin
      // Count write clamps and wipes the array
      if (cfg_we) begin
        live_count = cfg_wdata;
        if (live_count < 1) live_count = 1;
        if (live_count > ELEMENTS_DEF) live_count = ELEMENTS_DEF;
        clear_elems();
      end
      if (in_valid && in_ready) apply_word(command, range_low, range_high, value);
      // Compare each result word with the oldest expected sum
      if (out_valid && out_ready) begin
        if (sum_due.size() == 0) begin
          $display("%0t: unexpected range_sum %0d", $time, range_sum);
          fail_count++;
        end else begin
          if (range_sum !== sum_due[0]) begin
            $display("%0t: range_sum expected %0d actual %0d", $time, sum_due[0], range_sum);
            fail_count++;
          end
          void'(sum_due.pop_front());
          sums_checked++;
        end
      end
    end
    open_sums = sum_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rtc_pkg::*;

  localparam int LIMIT = 6000000;
  localparam int DRAIN = 4000;
  localparam int HOLD_LEN = 3000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    command = CMD_SUM;
  logic [CW-1:0] range_low = '0;
  logic [CW-1:0] range_high = '0;
  logic [VW-1:0] value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [SW-1:0] range_sum;

  int  fail_count;
  int  open_sums;
  int  sums_checked;
  int  words_sent = 0;
  int  send_idle = 0;
  int  recv_stall = 0;
  int  eff_count = ELEMENTS_DEF;
  int  cycle_count = 0;
  logic hold_go = 1'b0;
  int  hold_left = 0;

  range_totient_assign_sum_tree i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .range_low(range_low), .range_high(range_high), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum)
  );

  tb_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .range_low(range_low), .range_high(range_high), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum),
    .fail_count(fail_count), .open_sums(open_sums), .sums_checked(sums_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Offer one word; called at a clock edge, returns at its acceptance edge
  task automatic send(logic [1:0] cmd, int lo, int hi, logic [VW-1:0] v);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    range_low <= lo[CW-1:0];
    range_high <= hi[CW-1:0];
    value <= v;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Let the block drain, then write the element count
  task automatic write_count(logic [CW-1:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_sums != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_count = (c < 1) ? 1 : ((c > ELEMENTS_DEF) ? ELEMENTS_DEF : c);
  endtask

  // Random word, mostly short ranges with values that take several totient steps
  task automatic send_random();
    int sel;
    int lo;
    int hi;
    logic [1:0] cmd;
    logic [VW-1:0] v;
    sel = $urandom_range(99);
    cmd = (sel < 35) ? CMD_SUM : (sel < 65) ? CMD_SET : (sel < 95) ? CMD_PHI : CMD_NOP;
    sel = $urandom_range(99);
    if (sel < 4) begin
      lo = $urandom_range(2047);
      hi = $urandom_range(2047);
    end else if (sel < 9) begin
      hi = $urandom_range(eff_count);
      lo = hi + $urandom_range(5, 1);
    end else begin
      lo = $urandom_range(eff_count + 2);
      hi = lo + $urandom_range(15);
    end
    sel = $urandom_range(99);
    v = (sel < 50) ? VW'($urandom_range(200, 2)) :
        (sel < 90) ? VW'($urandom) : VW'($urandom_range(1));
    send(cmd, lo, hi, v);
  endtask

  initial begin
    int phase_cfg [6];
    phase_cfg = '{2047, 1, 0, 1024, 37, 500};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, every command, corner ranges
    send(CMD_SET, 1, 1024, 16'hFFFF);
    send(CMD_SUM, 1, 1024, 0);
    send(CMD_PHI, 1, 1024, 0);
    send(CMD_SUM, 0, 2047, 0);
    send(CMD_SET, 10, 20, 0);
    send(CMD_SET, 21, 30, 1);
    send(CMD_PHI, 1, 40, 0);
    send(CMD_SUM, 1, 40, 0);
    send(CMD_SUM, 30, 10, 0);
    send(CMD_SET, 1000, 2047, 2);
    send(CMD_SUM, 1020, 1024, 0);
    send(CMD_PHI, 1000, 2047, 0);
    send(CMD_SUM, 1000, 1024, 0);
    send(CMD_NOP, 1, 1024, 16'h5555);
    send(CMD_SUM, 5, 5, 0);
    send(CMD_SET, 0, 3, 16'h8000);
    send(CMD_PHI, 2, 2, 0);
    send(CMD_PHI, 2, 2, 0);
    send(CMD_SUM, 0, 4, 0);
    send(CMD_SUM, 2047, 2047, 0);

    for (int p = 0; p < 6; p++) begin
      write_count(phase_cfg[p][CW-1:0]);
      send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 65 : 32) : 0;
      recv_stall = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 32 : 0;
      if (p == 3) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        for (int i = 0; i < 30; i++) send(CMD_SUM, 1, $urandom_range(8), 0);
      end
      for (int i = 0; i < 130; i++) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (open_sums != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("tb: %0d words sent over 7 count settings, %0d sums checked", words_sent,
             sums_checked);
    $display("tb: totient, assign, sum and unknown commands, with idle and stall phases");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtc_pkg.sv
rtl/rtc_ram.sv
rtl/rtc_sieve.sv
rtl/rtc_range.sv
rtl/range_totient_assign_sum_tree.sv
bench/tb_checker.sv
bench/tb_top.sv
